### rtl/sgpb_pkg.sv
// Shared types, constants and helpers for the scroll glide pool brake.
// Used by every module of the block; depends on nothing.
package sgpb_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int IDX_W = $clog2(MAX_WINDOWS);
  localparam int CNT_W = IDX_W + 1;

  localparam int DIV_NUM_W = 60;
  localparam int DIV_DEN_W = 36;
  localparam int DIV_CNT_W = 6;

  // Rounded-up 2^57 / 1000; exact for a division by 1000 of any 48-bit value.
  localparam logic [47:0] RECIP_1000 = 48'h83126E978D50;

  localparam logic [1:0] REG_WINDOW_US = 2'd0;
  localparam logic [1:0] REG_POOL_MODE = 2'd1;

  localparam logic FUNC_FEED = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [19:0] WINDOW_US_RESET = 20'd100000;

  typedef struct packed {
    logic               func;
    logic signed [31:0] amount;
    logic signed [31:0] eat_rate;
    logic [23:0]        spit_gain;
    logic [15:0]        tick_us;
    logic signed [31:0] pool_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_amount;
    logic [4:0]         windows_left;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] q;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FEED_MUL,
    ST_FEED_WR,
    ST_SUM,
    ST_E_MUL,
    ST_E_GO,
    ST_E_WAIT,
    ST_S_GO,
    ST_S_WAIT,
    ST_RD,
    ST_SCALE,
    ST_OWN_GO,
    ST_OWN_WAIT,
    ST_PAY,
    ST_PAY_GO,
    ST_PAY_WAIT,
    ST_WR,
    ST_DONE
  } state_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

### rtl/sgpb_front.sv
// Input side of the scroll glide pool brake: a two-entry queue of accepted items.
// Depends on sgpb_pkg.
module sgpb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sgpb_pkg::in_item_t in_item,
  input  logic              pop,
  output logic              busy,
  output sgpb_pkg::q_head_t head
);
  import sgpb_pkg::*;

  in_item_t   ent [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] cnt;
  logic       push;

  assign busy = (cnt == 2'd2);
  assign push = start & ~busy;
  assign head.valid = (cnt != 2'd0);
  assign head.item = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/sgpb_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned.
// The numerator arrives left aligned; depends on sgpb_pkg.
module sgpb_div (
  input  logic               clk,
  input  logic               rst,
  input  sgpb_pkg::div_req_t req,
  output sgpb_pkg::div_rsp_t rsp
);
  import sgpb_pkg::*;

  logic [DIV_NUM_W-1:0] qr;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic                 done;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W+1:0] diff_r;

  assign rem_sh = {rem[DIV_DEN_W-1:0], qr[DIV_NUM_W-1]};
  assign diff_r = {1'b0, rem_sh} - {2'b00, den};
  assign rsp.busy = run;
  assign rsp.done = done;
  assign rsp.q = qr;

  always_ff @(posedge clk) begin
    if (req.start) begin
      qr <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (run) begin
      if (!diff_r[DIV_DEN_W+1]) begin
        rem <= diff_r[DIV_DEN_W:0];
        qr <= {qr[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        qr <= {qr[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.nbits;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/sgpb_back.sv
// Execution side of the scroll glide pool brake: window pool, brake, payout and aging.
// Depends on sgpb_pkg and drives the shared divider sgpb_div.
module sgpb_back (
  input  logic                clk,
  input  logic                rst,
  input  sgpb_pkg::q_head_t   head,
  output logic                pop,
  input  logic [19:0]         window_us,
  input  logic                pool_mode,
  output sgpb_pkg::div_req_t  div_req,
  input  sgpb_pkg::div_rsp_t  div_rsp,
  output logic                done,
  output sgpb_pkg::out_item_t result
);
  import sgpb_pkg::*;

  state_t state;
  state_t state_next;

  logic signed [31:0] amt_mem [MAX_WINDOWS];
  logic [19:0]        age_mem [MAX_WINDOWS];
  logic signed [31:0] rate_mem [MAX_WINDOWS];

  in_item_t           item;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   k;
  logic [35:0]        inflight;
  logic [35:0]        e_val;
  logic [24:0]        s_val;
  logic               brake_pool;
  logic [56:0]        mag_prod;
  logic               neg;
  logic signed [31:0] a_cur;
  logic [19:0]        age_cur;
  logic signed [31:0] rate_cur;
  logic signed [31:0] pay_val;
  logic signed [36:0] sum;

  logic [31:0]        mul_a;
  logic [24:0]        mul_b;
  logic [56:0]        mul_p;
  logic signed [31:0] rd_amt;
  logic [19:0]        rd_age;
  logic signed [31:0] rd_rate;
  logic [15:0]        dt;
  logic [20:0]        left;
  logic               pay_long;
  logic [40:0]        fmag;
  logic signed [31:0] feed_val;
  logic signed [31:0] sum_sat;
  logic signed [31:0] a_new;
  logic [20:0]        age_new;
  logic [47:0]        e_q;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic signed [31:0] wr_amt;
  logic [19:0]        wr_age;
  logic signed [31:0] wr_rate;

  logic               rcp_start;
  logic               rcp_run;
  logic               rcp_done;
  logic [1:0]         rcp_step;
  logic [47:0]        rcp_x;
  logic [23:0]        rcp_pa;
  logic [23:0]        rcp_pb;
  logic [47:0]        rcp_pp;
  logic [95:0]        rcp_add;
  logic [95:0]        rcp_acc;

  assign rd_amt = amt_mem[i[IDX_W-1:0]];
  assign rd_age = age_mem[i[IDX_W-1:0]];
  assign rd_rate = rate_mem[i[IDX_W-1:0]];
  assign dt = item.tick_us;
  assign mul_p = 57'(mul_a) * 57'(mul_b);
  assign left = {1'b0, window_us} - {1'b0, age_cur};
  assign pay_long = !left[20] && (left[19:0] > {4'b0000, dt});
  assign fmag = mag_prod[56:16];
  assign a_new = a_cur - pay_val;
  assign age_new = {1'b0, age_cur} + {5'b00000, dt};
  assign e_q = {9'd0, rcp_acc[95:57]};

  // The division by 1000 multiplies by a reciprocal in four 24 by 24 bit steps.
  assign rcp_pa = rcp_step[1] ? rcp_x[47:24] : rcp_x[23:0];
  assign rcp_pb = rcp_step[0] ? RECIP_1000[47:24] : RECIP_1000[23:0];
  assign rcp_pp = 48'(rcp_pa) * 48'(rcp_pb);

  always_comb begin
    case (rcp_step)
      2'd0: rcp_add = {48'd0, rcp_pp};
      2'd3: rcp_add = {rcp_pp, 48'd0};
      default: rcp_add = {24'd0, rcp_pp, 24'd0};
    endcase
  end

  always_comb begin
    if (item.spit_gain < 24'h010000) begin
      feed_val = item.amount;
    end else if (item.amount[31]) begin
      feed_val = (fmag > 41'h0080000000) ? 32'sh80000000 : -$signed(fmag[31:0]);
    end else begin
      feed_val = (fmag > 41'h007FFFFFFF) ? 32'sh7FFFFFFF : $signed(fmag[31:0]);
    end
  end

  always_comb begin
    if (sum > 37'sh007FFFFFFF) begin
      sum_sat = 32'sh7FFFFFFF;
    end else if (sum < -37'sh0080000000) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    div_req = '0;
    rcp_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    wr_en = 1'b0;
    wr_idx = k[IDX_W-1:0];
    wr_amt = a_new;
    wr_age = age_new[19:0];
    wr_rate = rate_cur;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.func == FUNC_FEED) begin
            state_next = (head.item.amount == 32'sd0) ? ST_IDLE : ST_FEED_MUL;
          end else if (window_us == 20'd0) begin
            state_next = ST_DONE;
          end else if (pool_mode && head.item.pool_rate > 32'sd0 && count != '0) begin
            state_next = ST_SUM;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_FEED_MUL: begin
        mul_a = mag32(item.amount);
        mul_b = 25'(item.spit_gain);
        state_next = ST_FEED_WR;
      end
      ST_FEED_WR: begin
        if (feed_val != 32'sd0 && count < CNT_W'(MAX_WINDOWS)) begin
          wr_en = 1'b1;
          wr_idx = count[IDX_W-1:0];
          wr_amt = feed_val;
          wr_age = 20'd0;
          wr_rate = item.eat_rate;
        end
        state_next = ST_IDLE;
      end
      ST_SUM: begin
        if (i == count) begin
          state_next = (inflight == 36'd0) ? ST_RD : ST_E_MUL;
        end
      end
      ST_E_MUL: begin
        mul_a = mag32(item.pool_rate);
        mul_b = 25'(dt);
        state_next = ST_E_GO;
      end
      ST_E_GO: begin
        rcp_start = 1'b1;
        state_next = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (rcp_done) begin
          state_next = ST_S_GO;
        end
      end
      ST_S_GO: begin
        div_req.start = 1'b1;
        div_req.num = {inflight - e_val, 24'd0};
        div_req.den = inflight;
        div_req.nbits = DIV_CNT_W'(60);
        state_next = ST_S_WAIT;
      end
      ST_S_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        if (i == count) begin
          state_next = ST_DONE;
        end else if (brake_pool) begin
          mul_a = mag32(rd_amt);
          mul_b = s_val;
          state_next = ST_SCALE;
        end else if (!pool_mode && rd_rate > 32'sd0) begin
          mul_a = mag32(rd_rate);
          mul_b = 25'(dt);
          state_next = ST_OWN_GO;
        end else begin
          state_next = ST_PAY;
        end
      end
      ST_SCALE: begin
        state_next = ST_PAY;
      end
      ST_OWN_GO: begin
        rcp_start = 1'b1;
        state_next = ST_OWN_WAIT;
      end
      ST_OWN_WAIT: begin
        if (rcp_done) begin
          state_next = ST_PAY;
        end
      end
      ST_PAY: begin
        if (pay_long) begin
          mul_a = mag32(a_cur);
          mul_b = 25'(dt);
          state_next = ST_PAY_GO;
        end else begin
          state_next = ST_WR;
        end
      end
      ST_PAY_GO: begin
        div_req.start = 1'b1;
        div_req.num = {mag_prod[47:0], 12'd0};
        div_req.den = {16'd0, left[19:0]};
        div_req.nbits = DIV_CNT_W'(48);
        state_next = ST_PAY_WAIT;
      end
      ST_PAY_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_WR;
        end
      end
      ST_WR: begin
        if (age_new < {1'b0, window_us}) begin
          wr_en = 1'b1;
        end
        state_next = ST_RD;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcp_run <= 1'b0;
      rcp_done <= 1'b0;
      rcp_step <= 2'd0;
    end else begin
      rcp_done <= 1'b0;
      if (rcp_start) begin
        rcp_run <= 1'b1;
        rcp_step <= 2'd0;
      end else if (rcp_run) begin
        rcp_step <= rcp_step + 2'd1;
        if (rcp_step == 2'd3) begin
          rcp_run <= 1'b0;
          rcp_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rcp_start) begin
      rcp_x <= mag_prod[47:0];
      rcp_acc <= '0;
    end else if (rcp_run) begin
      rcp_acc <= rcp_acc + rcp_add;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      amt_mem[wr_idx] <= wr_amt;
      age_mem[wr_idx] <= wr_age;
      rate_mem[wr_idx] <= wr_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FEED_MUL || state == ST_E_MUL || state == ST_RD || state == ST_PAY) begin
      mag_prod <= mul_p;
    end
    unique case (state)
      ST_IDLE: begin
        item <= head.item;
        i <= '0;
        k <= '0;
        sum <= '0;
        inflight <= '0;
        brake_pool <= 1'b0;
        result <= '0;
      end
      ST_SUM: begin
        if (i == count) begin
          i <= '0;
        end else begin
          inflight <= inflight + 36'(mag32(rd_amt));
          i <= i + 1'b1;
        end
      end
      ST_E_WAIT: begin
        if (rcp_done) begin
          e_val <= (e_q > 48'(inflight)) ? inflight : e_q[35:0];
        end
      end
      ST_S_WAIT: begin
        if (div_rsp.done) begin
          s_val <= div_rsp.q[24:0];
          brake_pool <= 1'b1;
        end
      end
      ST_RD: begin
        a_cur <= rd_amt;
        age_cur <= rd_age;
        rate_cur <= rd_rate;
        neg <= rd_amt[31];
        if (i == count) begin
          result.out_amount <= sum_sat;
          result.windows_left <= 5'(k);
        end
      end
      ST_SCALE: begin
        a_cur <= neg ? -$signed(mag_prod[55:24]) : $signed(mag_prod[55:24]);
      end
      ST_OWN_WAIT: begin
        if (rcp_done) begin
          if (e_q >= {16'd0, mag32(a_cur)}) begin
            a_cur <= 32'sd0;
          end else if (a_cur[31]) begin
            a_cur <= a_cur + $signed(e_q[31:0]);
          end else begin
            a_cur <= a_cur - $signed(e_q[31:0]);
          end
        end
      end
      ST_PAY: begin
        neg <= a_cur[31];
        pay_val <= a_cur;
      end
      ST_PAY_WAIT: begin
        if (div_rsp.done) begin
          pay_val <= neg ? -$signed(div_rsp.q[31:0]) : $signed(div_rsp.q[31:0]);
        end
      end
      ST_WR: begin
        sum <= sum + 37'(pay_val);
        i <= i + 1'b1;
        if (wr_en) begin
          k <= k + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == ST_FEED_WR && wr_en) begin
      count <= count + 1'b1;
    end else if (state == ST_RD && i == count) begin
      count <= k;
    end else if (state == ST_IDLE && head.valid && head.item.func == FUNC_TICK &&
                 window_us == 20'd0) begin
      count <= '0;
    end
  end

  assign done = (state == ST_DONE);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_WINDOWS))
    else $error("window count above pool size");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_rcp_free: assert property (@(posedge clk) disable iff (rst)
    rcp_start |-> !rcp_run)
    else $error("reciprocal unit started while busy");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    done |-> result.windows_left == 5'(count))
    else $error("reported window count differs from pool");

  a_compact: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR || state == ST_RD) |-> k <= i)
    else $error("write index passed read index");

endmodule

### rtl/scroll_glide_pool_brake.sv
// Top level of the scroll glide pool brake: configuration registers and the front queue,
// back engine and shared divider. Depends on sgpb_pkg, sgpb_front, sgpb_back and sgpb_div.
//
// An item is taken when start is high and busy is low; two items can wait in the queue.
// A feed item passes a multiply step and a write step, or none when its amount is zero.
// A tick item presents one result for one cycle on done and result, which the receiver
// cannot hold off and must take then. A tick walks the windows with a read, a payout and a
// write step per window, plus an own-rate brake or a shared-rate scale, and the payout
// division when the window is not in its final tick. In shared-rate mode with a positive
// rate and a non-empty pool, the magnitude sum and the two pool steps come first. The
// one-bit-per-cycle payout divider sets most of a tick's length, above all for a full
// pool of sixteen windows.
module scroll_glide_pool_brake (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sgpb_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [19:0]         cfg_data,
  output logic                done,
  output sgpb_pkg::out_item_t result
);
  import sgpb_pkg::*;

  logic [19:0] window_us;
  logic        pool_mode;
  q_head_t     head;
  logic        pop;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_us <= WINDOW_US_RESET;
      pool_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_US: window_us <= cfg_data;
        REG_POOL_MODE: pool_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sgpb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_item (in_item),
    .pop     (pop),
    .busy    (busy),
    .head    (head)
  );

  sgpb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sgpb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .window_us (window_us),
    .pool_mode (pool_mode),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .done      (done),
    .result    (result)
  );

endmodule

### tb/tb_scroll_glide_pool_brake.sv
// Self-checking testbench for the scroll glide pool brake: drives feed and tick items,
// predicts each tick's payout in a scoreboard class, and compares every result.
// Depends on sgpb_pkg and the scroll_glide_pool_brake top level.
module tb_scroll_glide_pool_brake;
  import sgpb_pkg::*;

  class glide_scoreboard;
    logic signed [31:0] amt [MAX_WINDOWS];
    logic [19:0]        age [MAX_WINDOWS];
    logic signed [31:0] rate [MAX_WINDOWS];
    int                 count;
    logic [19:0]        win_us;
    logic               mode;
    out_item_t          pending [$];
    int                 errors;

    function new();
      count = 0;
      win_us = WINDOW_US_RESET;
      mode = 1'b0;
      errors = 0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void note_config(logic [1:0] idx, logic [19:0] data);
      if (idx == REG_WINDOW_US) win_us = data;
      else if (idx == REG_POOL_MODE) mode = data[0];
    endfunction

    function void note_item(in_item_t it);
      longint a, e, inflight, s, sum, left, pay, dt, na;
      int k;
      out_item_t r;
      if (it.func == FUNC_FEED) begin
        a = longint'(it.amount);
        if (a == 0) return;
        if (it.spit_gain >= 24'd65536) a = sat(a * longint'(it.spit_gain) / 65536);
        if (a == 0 || count >= MAX_WINDOWS) return;
        amt[count] = 32'(a);
        age[count] = '0;
        rate[count] = it.eat_rate;
        count++;
        return;
      end
      dt = longint'(it.tick_us);
      if (win_us == 0) begin
        count = 0;
        r.out_amount = '0;
        r.windows_left = '0;
        pending = {pending, r};
        return;
      end
      if (mode) begin
        if (it.pool_rate > 0 && count != 0) begin
          inflight = 0;
          for (int i = 0; i < count; i++) inflight += mag(amt[i]);
          if (inflight != 0) begin
            e = longint'(it.pool_rate) * dt / 1000;
            if (e > inflight) e = inflight;
            s = ((inflight - e) * (64'sd1 <<< 24)) / inflight;
            for (int i = 0; i < count; i++)
              amt[i] = 32'(longint'(amt[i]) * s / (64'sd1 <<< 24));
          end
        end
      end else begin
        for (int i = 0; i < count; i++) begin
          if (rate[i] > 0) begin
            a = amt[i];
            e = longint'(rate[i]) * dt / 1000;
            if (e >= mag(a)) a = 0;
            else a = (a < 0) ? a + e : a - e;
            amt[i] = 32'(a);
          end
        end
      end
      sum = 0;
      k = 0;
      for (int i = 0; i < count; i++) begin
        a = amt[i];
        left = longint'(win_us) - longint'(age[i]);
        pay = a;
        if (left > dt) pay = a * dt / left;
        sum += pay;
        na = longint'(age[i]) + dt;
        if (na < longint'(win_us)) begin
          amt[k] = 32'(a - pay);
          age[k] = 20'(na);
          rate[k] = rate[i];
          k++;
        end
      end
      count = k;
      r.out_amount = 32'(sat(sum));
      r.windows_left = count[4:0];
      pending = {pending, r};
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report_error("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.out_amount !== want.out_amount)
        report_error($sformatf("out_amount %0d, expected %0d", got.out_amount, want.out_amount));
      if (got.windows_left !== want.windows_left)
        report_error($sformatf("windows_left %0d, expected %0d",
                               got.windows_left, want.windows_left));
    endtask

    task report_error(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        done;
  out_item_t   result;
  logic        calm = 1'b0;

  glide_scoreboard board = new();

  scroll_glide_pool_brake dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
    if (!rst && start && !busy) board.note_item(in_item);
  end

  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] idx, logic [19:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.note_config(idx, data);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_amount();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic in_item_t rand_feed();
    in_item_t it;
    it = '0;
    it.func = FUNC_FEED;
    it.amount = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_amount();
    it.eat_rate = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
    case ($urandom_range(0, 3))
      0: it.spit_gain = 24'($urandom);
      1: it.spit_gain = 24'($urandom_range(0, 65535));
      default: it.spit_gain = 24'($urandom_range(65536, 3 * 65536));
    endcase
    it.tick_us = 16'($urandom);
    it.pool_rate = $urandom;
    return it;
  endfunction

  function automatic in_item_t rand_tick();
    in_item_t it;
    it = '0;
    it.func = FUNC_TICK;
    it.tick_us = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20000));
    it.pool_rate = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1 << 24);
    it.amount = $urandom;
    it.eat_rate = $urandom;
    it.spit_gain = 24'($urandom);
    return it;
  endfunction

  task automatic directed_part();
    in_item_t it;
    it = rand_feed(); it.amount = 0; send_item(it);
    it = rand_feed(); it.amount = 32'h7fffffff; it.spit_gain = 24'hffffff; send_item(it);
    it = rand_feed(); it.amount = 32'h80000000; it.spit_gain = 24'hffffff; send_item(it);
    it = rand_feed(); it.amount = 1; it.spit_gain = 24'd65536; it.eat_rate = 0; send_item(it);
    it = rand_feed(); it.amount = -5; it.eat_rate = 32'h80000000; send_item(it);
    it = rand_tick(); it.tick_us = 0; send_item(it);
    it = rand_tick(); it.tick_us = 16'hffff; send_item(it);
    for (int i = 0; i < 18; i++) send_item(rand_feed());
    it = rand_tick(); it.tick_us = 1000; send_item(it);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) send_item(rand_tick());
      else send_item(rand_feed());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part();
    write_config(REG_POOL_MODE, 20'd1);
    directed_part();
    random_phase(120);
    write_config(REG_WINDOW_US, 20'hfffff);
    random_phase(120);
    write_config(REG_POOL_MODE, 20'd0);
    write_config(REG_WINDOW_US, 20'd3000);
    random_phase(120);
    write_config(REG_WINDOW_US, 20'd1);
    random_phase(60);
    write_config(REG_WINDOW_US, 20'd0);
    random_phase(40);
    write_config(REG_WINDOW_US, 20'd20000);
    write_config(REG_POOL_MODE, 20'd1);
    random_phase(120);
    write_config(REG_WINDOW_US, 20'd5000);
    random_phase(100);
    calm <= 1'b1;
    write_config(REG_POOL_MODE, 20'd0);
    random_phase(120);
    drain();
    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #200000000;
    $display("simulation failed");
    $finish;
  end
endmodule
